[sv/ifad_pkg.sv]
package ifad_pkg;

  // time width default, masks every timestamp inside the block
  localparam int TIME_WIDTH_DEF = 32;

  localparam int ACCEL_W  = 16;
  localparam int SQ_W     = 32;
  localparam int TSTAMP_W = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int WINDOW_W = 16;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_TRIGGER = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_LOST    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    RSN_IMPACT   = 2'd0,
    RSN_FREEFALL = 2'd1,
    RSN_MANUAL   = 2'd2
  } reason_t;

  typedef enum logic [1:0] {
    LVL_CLEAR    = 2'd0,
    LVL_WARNING  = 2'd1,
    LVL_CRITICAL = 2'd2
  } level_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WARNING_LEVEL  = 3'd0,
    CFG_IMPACT_LEVEL   = 3'd1,
    CFG_FREEFALL_LEVEL = 3'd2,
    CFG_FREEFALL_WIN   = 3'd3,
    CFG_ALERT_HOLD     = 3'd4,
    CFG_COOLDOWN       = 3'd5
  } cfg_idx_t;

  // register reset values, squared raw counts at 4096 counts per g
  localparam logic [CFG_W-1:0]    WARNING_LEVEL_RST  = 32'd48486154;
  localparam logic [CFG_W-1:0]    IMPACT_LEVEL_RST   = 32'd122305905;
  localparam logic [CFG_W-1:0]    FREEFALL_LEVEL_RST = 32'd2055209;
  localparam logic [WINDOW_W-1:0] FREEFALL_WIN_RST   = 16'd2000;
  localparam logic [CFG_W-1:0]    ALERT_HOLD_RST     = 32'd30000;
  localparam logic [CFG_W-1:0]    COOLDOWN_RST       = 32'd30000;

endpackage

[sv/impact_freefall_alert_detector.sv]
// impact and free-fall alert detector
// input channel: one word per command or timestamped three-axis sample
//   (in_opcode, in_accel_x/y/z, in_time_ms), moved when in_valid is high
//   and in_stall is low
// result channel: one word per input word (alert level, report flags,
//   squared magnitude, peak and sensor status), moved when out_valid is
//   high and out_stall is low
// config port: cfg_wr_en writes cfg_wdata into register cfg_index at the
//   clock edge; only write while no word is in flight
// latency: a word taken at one edge shows on the result port after the
//   second edge that follows it (input register, squares register, result
//   register)
// throughput: one word per cycle; the three 16x16 squares sit in their own
//   stage, the sum, threshold compares and alert state update in the next
// a stalled result holds; the pipeline keeps filling behind it until all
//   three stages are full, then in_stall rises in the same cycle
// reset (rst_n low, synchronous): pipeline empties, alert state clears,
//   sensor is taken as working and the registers return to defaults
module impact_freefall_alert_detector #(
  parameter int TIME_WIDTH = ifad_pkg::TIME_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_opcode,
  input  logic signed [ifad_pkg::ACCEL_W-1:0]  in_accel_x,
  input  logic signed [ifad_pkg::ACCEL_W-1:0]  in_accel_y,
  input  logic signed [ifad_pkg::ACCEL_W-1:0]  in_accel_z,
  input  logic [ifad_pkg::TSTAMP_W-1:0]        in_time_ms,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_alert_level,
  output logic                                 out_report_valid,
  output logic [1:0]                           out_report_reason,
  output logic                                 out_report_is_repeat,
  output logic [ifad_pkg::SQ_W-1:0]            out_magnitude_sq,
  output logic [ifad_pkg::SQ_W-1:0]            out_peak_magnitude_sq,
  output logic                                 out_sensor_good,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [ifad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ifad_pkg::CFG_W-1:0]           cfg_wdata
);

  // wide compare width: a time difference against a 32-bit register
  localparam int CW = TIME_WIDTH + ifad_pkg::CFG_W;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [ifad_pkg::CFG_W-1:0]    warn_lvl_r, impact_lvl_r, ff_lvl_r;
  logic [ifad_pkg::WINDOW_W-1:0] ff_win_r;
  logic [ifad_pkg::CFG_W-1:0]    hold_r, cooldown_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_lvl_r   <= ifad_pkg::WARNING_LEVEL_RST;
      impact_lvl_r <= ifad_pkg::IMPACT_LEVEL_RST;
      ff_lvl_r     <= ifad_pkg::FREEFALL_LEVEL_RST;
      ff_win_r     <= ifad_pkg::FREEFALL_WIN_RST;
      hold_r       <= ifad_pkg::ALERT_HOLD_RST;
      cooldown_r   <= ifad_pkg::COOLDOWN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ifad_pkg::CFG_WARNING_LEVEL:  warn_lvl_r   <= cfg_wdata;
        ifad_pkg::CFG_IMPACT_LEVEL:   impact_lvl_r <= cfg_wdata;
        ifad_pkg::CFG_FREEFALL_LEVEL: ff_lvl_r     <= cfg_wdata;
        ifad_pkg::CFG_FREEFALL_WIN:   ff_win_r     <= cfg_wdata[ifad_pkg::WINDOW_W-1:0];
        ifad_pkg::CFG_ALERT_HOLD:     hold_r       <= cfg_wdata;
        ifad_pkg::CFG_COOLDOWN:       cooldown_r   <= cfg_wdata;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // pipeline flow control: each stage moves when the next one has room
  // ---------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic out_take, s2_free, s2_adv, s1_free, s1_adv, in_acc;

  assign out_take = !out_valid_r || !out_stall;
  assign s2_free  = !s2_valid_r || out_take;
  assign s2_adv   = s2_valid_r && out_take;
  assign s1_free  = !s1_valid_r || s2_free;
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_stall = !s1_free;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free)  s1_valid_r  <= in_valid;
      if (s2_free)  s2_valid_r  <= s1_valid_r;
      if (out_take) out_valid_r <= s2_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------
  // stage 1: input register
  // ---------------------------------------------------------------------
  logic [1:0]                          s1_op_r;
  logic signed [ifad_pkg::ACCEL_W-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [ifad_pkg::TSTAMP_W-1:0]       s1_time_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_opcode;
      s1_x_r    <= in_accel_x;
      s1_y_r    <= in_accel_y;
      s1_z_r    <= in_accel_z;
      s1_time_r <= in_time_ms;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: per-axis squares and masked timestamp
  // ---------------------------------------------------------------------
  function automatic logic [ifad_pkg::SQ_W-1:0] sq_axis(
    input logic signed [ifad_pkg::ACCEL_W-1:0] v
  );
    logic [ifad_pkg::ACCEL_W-1:0] a;
    // magnitude as unsigned, full scale negative gives 0x8000
    a = v[ifad_pkg::ACCEL_W-1] ? ifad_pkg::ACCEL_W'(~v + 1'b1)
                               : ifad_pkg::ACCEL_W'(v);
    return ifad_pkg::SQ_W'(a) * ifad_pkg::SQ_W'(a);
  endfunction

  logic [TIME_WIDTH+ifad_pkg::TSTAMP_W-1:0] time_ext;
  assign time_ext = {{TIME_WIDTH{1'b0}}, s1_time_r};

  logic [1:0]                s2_op_r;
  logic [ifad_pkg::SQ_W-1:0] s2_sqx_r, s2_sqy_r, s2_sqz_r;
  logic [TIME_WIDTH-1:0]     s2_now_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_op_r  <= s1_op_r;
      s2_sqx_r <= sq_axis(s1_x_r);
      s2_sqy_r <= sq_axis(s1_y_r);
      s2_sqz_r <= sq_axis(s1_z_r);
      s2_now_r <= time_ext[TIME_WIDTH-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // detector state
  // ---------------------------------------------------------------------
  logic                      alive_r, ff_seen_r, rep_seen_r;
  logic [ifad_pkg::SQ_W-1:0] cur_sq_r, peak_sq_r;
  logic [TIME_WIDTH-1:0]     ff_time_r, end_time_r, last_rep_r;
  logic [1:0]                reason_r;

  logic                      alive_nxt, ff_seen_nxt, rep_seen_nxt;
  logic [ifad_pkg::SQ_W-1:0] cur_sq_nxt, peak_sq_nxt;
  logic [TIME_WIDTH-1:0]     ff_time_nxt, end_time_nxt, last_rep_nxt;
  logic [1:0]                reason_nxt;

  logic [ifad_pkg::SQ_W-1:0] mag;
  logic                      samp, is_trig, is_clear, is_lost;
  logic                      hit_impact, hit_ff, fire, repeat_rep, report;
  logic [TIME_WIDTH-1:0]     ff_diff, rep_diff;
  logic [CW-1:0]             hold_sum;
  logic [1:0]                fire_reason, level_nxt;

  // squares are at most 2^30 each, the sum fits 32 bits
  assign mag = s2_sqx_r + s2_sqy_r + s2_sqz_r;

  always_comb begin
    samp     = (s2_op_r == ifad_pkg::OP_SAMPLE) && alive_r;
    is_trig  = (s2_op_r == ifad_pkg::OP_TRIGGER);
    is_clear = (s2_op_r == ifad_pkg::OP_CLEAR);
    is_lost  = (s2_op_r == ifad_pkg::OP_LOST);

    alive_nxt   = alive_r && !is_lost;
    cur_sq_nxt  = samp ? mag : cur_sq_r;
    peak_sq_nxt = (samp && (mag > peak_sq_r)) ? mag : peak_sq_r;

    // a quiet sample marks free fall before the shock test sees it
    ff_seen_nxt = ff_seen_r;
    ff_time_nxt = ff_time_r;
    if (samp && (mag <= ff_lvl_r)) begin
      ff_seen_nxt = 1'b1;
      ff_time_nxt = s2_now_r;
    end
    ff_diff = s2_now_r - ff_time_nxt;

    hit_impact = samp && (mag >= impact_lvl_r);
    hit_ff     = samp && !hit_impact && ff_seen_nxt
                 && (CW'(ff_diff) <= CW'(ff_win_r))
                 && (mag >= warn_lvl_r);
    fire       = hit_impact || hit_ff || is_trig;

    if (is_trig)      fire_reason = ifad_pkg::RSN_MANUAL;
    else if (hit_ff)  fire_reason = ifad_pkg::RSN_FREEFALL;
    else              fire_reason = ifad_pkg::RSN_IMPACT;

    // alert end wraps within the time width
    hold_sum = CW'(s2_now_r) + CW'(hold_r);

    end_time_nxt = end_time_r;
    reason_nxt   = reason_r;
    last_rep_nxt = last_rep_r;
    rep_seen_nxt = rep_seen_r;
    if (fire) begin
      end_time_nxt = hold_sum[TIME_WIDTH-1:0];
      reason_nxt   = fire_reason;
      last_rep_nxt = s2_now_r;
      rep_seen_nxt = 1'b1;
    end else if (is_clear) begin
      end_time_nxt = '0;
      reason_nxt   = ifad_pkg::RSN_IMPACT;
    end

    // cooldown repeat, only on words that raised no report of their own
    rep_diff   = s2_now_r - last_rep_r;
    repeat_rep = !fire && (s2_now_r < end_time_nxt)
                 && (!rep_seen_r || (CW'(rep_diff) >= CW'(cooldown_r)));
    if (repeat_rep) begin
      last_rep_nxt = s2_now_r;
      rep_seen_nxt = 1'b1;
    end
    report = fire || repeat_rep;

    if (s2_now_r < end_time_nxt)
      level_nxt = ifad_pkg::LVL_CRITICAL;
    else if (alive_nxt && (cur_sq_nxt >= warn_lvl_r))
      level_nxt = ifad_pkg::LVL_WARNING;
    else
      level_nxt = ifad_pkg::LVL_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r    <= 1'b1;
      cur_sq_r   <= '0;
      peak_sq_r  <= '0;
      ff_seen_r  <= 1'b0;
      ff_time_r  <= '0;
      end_time_r <= '0;
      rep_seen_r <= 1'b0;
      last_rep_r <= '0;
      reason_r   <= ifad_pkg::RSN_IMPACT;
    end else if (s2_adv) begin
      alive_r    <= alive_nxt;
      cur_sq_r   <= cur_sq_nxt;
      peak_sq_r  <= peak_sq_nxt;
      ff_seen_r  <= ff_seen_nxt;
      ff_time_r  <= ff_time_nxt;
      end_time_r <= end_time_nxt;
      rep_seen_r <= rep_seen_nxt;
      last_rep_r <= last_rep_nxt;
      reason_r   <= reason_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_alert_level       <= level_nxt;
      out_report_valid      <= report;
      out_report_reason     <= report ? reason_nxt : ifad_pkg::RSN_IMPACT;
      out_report_is_repeat  <= repeat_rep;
      out_magnitude_sq      <= cur_sq_nxt;
      out_peak_magnitude_sq <= peak_sq_nxt;
      out_sensor_good       <= alive_nxt;
    end
  end

endmodule
